@@ rtl/suc_pkg.sv @@
// Shared types and result codes for the sorted unique set insert unit.
package suc_pkg;

  // Result status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic sample;  // compare the incoming value this cycle
    logic commit;  // insert: cells at or past the boundary take new data
  } suc_cell_ctl_t;

endpackage

@@ rtl/suc_cell.sv @@
// One slot of the sorted array: holds an entry, compares, shifts up on insert.
module suc_cell import suc_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic              clk,
  input  suc_cell_ctl_t     ctl,
  input  logic [CNT_W-1:0]  held_count,
  input  logic signed [31:0] cmp_value,
  input  logic signed [31:0] ins_value,
  input  logic              left_lt,
  input  logic signed [31:0] left_entry,
  output logic              lt,
  output logic              eq,
  output logic              boundary,
  output logic signed [31:0] entry
);

  logic signed [31:0] entry_r, entry_nxt;
  logic               lt_r, lt_nxt;
  logic               eq_r, eq_nxt;
  logic               held;

  // Entries at or above the count are never looked at
  assign held = held_count > CNT_W'(IDX);

  always_comb begin
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    entry_nxt = entry_r;
    if (ctl.sample) begin
      lt_nxt = held && (entry_r < cmp_value);
      eq_nxt = held && (entry_r == cmp_value);
    end
    if (ctl.commit && !lt_r) begin
      entry_nxt = left_lt ? ins_value : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
    entry_r <= entry_nxt;
  end

  assign lt       = lt_r;
  assign eq       = eq_r;
  assign boundary = left_lt && !lt_r;
  assign entry    = entry_r;

endmodule

@@ rtl/sorted_unique_set_insert_unit.sv @@
// Top level of the sorted unique set insert unit: cell chain and sequencer.
//
// Keeps an ascending set of distinct signed 32-bit values, up to CAPACITY
// entries, in a row of cells. On the accepting edge (start high, busy low)
// every cell compares its entry with in_new_value and registers less-than /
// equal flags; in the next cycle (busy high) the equal flags decide
// duplicate, the count decides full, and on an insert every cell at or past
// the first not-less cell takes either the new value or its lower neighbor's
// entry, so the whole set shifts up by one at that edge. The result is driven
// from registers for exactly one cycle, flagged by out_valid, the cycle after
// that; busy is already low then, so a new transaction can start while the
// result is shown, but none is taken while busy is high: the compare stage
// is followed by the shift stage. The receiver cannot stall, so results must
// be taken when out_valid is high. Status: inserted, duplicate (slot where
// the value already sits, reported even when full) or full (value dropped,
// slot 0, count unchanged). Slot and count are truncated to 5 and 6 bits for
// large CAPACITY. No clearing pass after reset: the entry storage is only
// read below the count.
module sorted_unique_set_insert_unit import suc_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic signed [31:0] in_new_value,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [4:0]        out_slot,
  output logic [5:0]        out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // sequencer / count
  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic signed [31:0] value_r, value_nxt;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [4:0]        slot_r, slot_nxt;
  logic [5:0]        ecount_r, ecount_nxt;

  logic              accept;
  suc_cell_ctl_t     ctl;

  // per-cell wires
  logic [CAPACITY-1:0]       lt_vec, eq_vec, bnd_vec;
  logic signed [31:0]        entry_vec [CAPACITY];
  logic [IDX_W-1:0]          slot_enc;
  logic                      dup, full;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  assign dup  = |eq_vec;
  assign full = count_r == CNT_W'(CAPACITY);

  assign ctl.sample = accept;
  assign ctl.commit = busy_r && !dup && !full;

  // Cell chain: cell 0 sees "left is less" as true, so it is the boundary
  // when no entry is below the new value.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic              l_lt;
    logic signed [31:0] l_entry;
    if (g == 0) begin : g_head
      assign l_lt    = 1'b1;
      assign l_entry = value_r;
    end else begin : g_body
      assign l_lt    = lt_vec[g-1];
      assign l_entry = entry_vec[g-1];
    end
    suc_cell #(.IDX(g), .CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .held_count (count_r),
      .cmp_value  (in_new_value),
      .ins_value  (value_r),
      .left_lt    (l_lt),
      .left_entry (l_entry),
      .lt         (lt_vec[g]),
      .eq         (eq_vec[g]),
      .boundary   (bnd_vec[g]),
      .entry      (entry_vec[g])
    );
  end

  // Boundary has at most one bit set (flags are a thermometer over the sorted cells):
  // the slot is an OR of the indices of set bits.
  always_comb begin
    slot_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd_vec[i]) slot_enc = slot_enc | IDX_W'(i);
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    ecount_nxt    = ecount_r;
    if (accept) begin
      busy_nxt  = 1'b1;
      value_nxt = in_new_value;
    end
    if (busy_r) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (dup) begin
        status_nxt = ST_DUPLICATE;
        slot_nxt   = 5'(slot_enc);
      end else if (full) begin
        status_nxt = ST_FULL;
        slot_nxt   = '0;
      end else begin
        status_nxt = ST_INSERTED;
        slot_nxt   = 5'(slot_enc);
        count_nxt  = count_r + 1'b1;
      end
      ecount_nxt = 6'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r  <= value_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    ecount_r <= ecount_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot        = slot_r;
  assign out_entry_count = ecount_r;

endmodule

@@ tb/sorted_unique_set_insert_unit_test.sv @@
// Self-checking testbench for the sorted unique set insert unit.
module sorted_unique_set_insert_unit_test import suc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Depth of the set under test; the model below tracks the same depth.
  localparam int SET_DEPTH = 32;
  localparam int RANDOM_ITEMS = 380;
  // Random items after this index run back to back, with no sender gaps.
  localparam int QUIET_TAIL_START = 300;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

  // One expected result of an insert transaction.
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot;
    logic [5:0] entry_count;
  } insert_outcome_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic signed [31:0] in_new_value;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [4:0]        out_slot;
  logic [5:0]        out_entry_count;

  // Model copy of the set: ascending values below held_total.
  logic signed [31:0] model_entries [SET_DEPTH];
  int                 held_total;

  insert_outcome_t pending_outcomes[$];

  int  error_total;
  int  checked_total;
  int  inserted_seen;
  int  duplicate_seen;
  int  dropped_seen;
  bit  gaps_on;

  sorted_unique_set_insert_unit #(
    .CAPACITY(SET_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_new_value(in_new_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_slot(out_slot),
    .out_entry_count(out_entry_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Model of one insert: count the entries below the value, then decide
  // duplicate (checked first, so it wins even when full), full, or insert
  // with everything above the boundary moving up a slot.
  function automatic insert_outcome_t model_insert(logic signed [31:0] value);
    int below;
    insert_outcome_t outcome;
    below = 0;
    for (int i = 0; i < held_total; i++) begin
      if (model_entries[i] < value) below++;
    end
    if (below < held_total && model_entries[below] == value) begin
      outcome.status = ST_DUPLICATE;
      outcome.slot = 5'(below);
    end else if (held_total >= SET_DEPTH) begin
      outcome.status = ST_FULL;
      outcome.slot = 5'd0;
    end else begin
      for (int i = held_total; i > below; i--) begin
        model_entries[i] = model_entries[i - 1];
      end
      model_entries[below] = value;
      held_total++;
      outcome.status = ST_INSERTED;
      outcome.slot = 5'(below);
    end
    outcome.entry_count = 6'(held_total);
    return outcome;
  endfunction

  // Drive one value and hold it until the unit takes it. Called at a falling
  // edge and returns at a falling edge. start is left high on return so that
  // back-to-back transactions never lower and raise it within one step.
  task automatic send_value(input logic signed [31:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    start <= 1'b1;
    in_new_value <= value;
    // busy read here is the value before this edge's updates
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(model_insert(value));
    @(negedge clk);
  endtask

  // Value already in the model set, picked at random.
  function automatic logic signed [31:0] held_value_pick();
    return model_entries[$urandom_range(0, held_total - 1)];
  endfunction

  // Empty set first: extremes, both ends, middle placement and duplicates.
  task automatic test_empty_set_edges();
    send_value(32'sd0);
    send_value(32'sd0);
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value(-32'sd1);
    send_value(32'sd1);
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value(32'sh5555_5555);
    send_value(32'shaaaa_aaaa);
  endtask

  // Random values until the set is full; some values repeat on purpose.
  task automatic test_fill_to_capacity();
    logic signed [31:0] value;
    while (held_total < SET_DEPTH) begin
      case ($urandom_range(0, 4))
        0: value = held_value_pick();
        1: value = held_value_pick() + 32'sd1;
        2: value = 32'($urandom_range(0, 15)) - 32'sd8;
        default: value = $urandom;
      endcase
      send_value(value);
    end
  endtask

  // Full set: duplicates at both ends keep their slot, new values drop.
  task automatic test_full_set();
    send_value(model_entries[0]);
    send_value(model_entries[SET_DEPTH - 1]);
    send_value(model_entries[SET_DEPTH / 2]);
    send_value(VALUE_MIN);
    send_value(VALUE_MAX);
    send_value(model_entries[0] - 32'sd1);
    send_value(model_entries[SET_DEPTH - 1] + 32'sd1);
    send_value(model_entries[3] + 32'sd1);
  endtask

  // Half held values (duplicate path across random slots), the rest near
  // misses and fully random values that get dropped.
  task automatic test_random_traffic();
    logic signed [31:0] value;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // sender gaps come in stretches; none in the tail
      gaps_on = (n < QUIET_TAIL_START) && ((n / 30) % 3 != 2);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: value = held_value_pick();
        5: value = held_value_pick() + 32'sd1;
        6: value = held_value_pick() - 32'sd1;
        default: value = $urandom;
      endcase
      send_value(value);
    end
  endtask

  // Result checker: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    insert_outcome_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d slot %0d count %0d",
               out_status, out_slot, out_entry_count);
        error_total++;
      end else begin
        want = pending_outcomes.pop_front();
        checked_total++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_total++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          error_total++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 want.entry_count, out_entry_count);
          error_total++;
        end
        case (want.status)
          ST_INSERTED:  inserted_seen++;
          ST_DUPLICATE: duplicate_seen++;
          default:      dropped_seen++;
        endcase
      end
    end
  end

  initial begin
    int drain_wait;
    error_total = 0;
    checked_total = 0;
    inserted_seen = 0;
    duplicate_seen = 0;
    dropped_seen = 0;
    held_total = 0;
    gaps_on = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_new_value = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_set_edges();
    gaps_on = 1'b1;
    test_fill_to_capacity();
    test_full_set();
    test_random_traffic();
    start <= 1'b0;

    // drain: wait until every expected result has arrived
    drain_wait = 0;
    while (pending_outcomes.size() != 0 && drain_wait < 1000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (10) @(negedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", pending_outcomes.size());
      error_total++;
    end

    $display("Checked %0d transactions: %0d placed, %0d already held, %0d dropped",
             checked_total, inserted_seen, duplicate_seen, dropped_seen);
    $display("Set filled to %0d entries, then exercised while full", held_total);
    if (error_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Timeout waiting on the unit");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
